>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, constants and the square-root step of the Sobel edge core.
// ----------------------------------------------------------------------------
package sem_pkg;

    // Field widths of the streams
    localparam int CH_W           = 8;
    localparam int PIX_W          = 3 * CH_W;
    localparam int LINE_W         = 2 * PIX_W;
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W          = FRAME_HEIGHT_W;
    localparam int OUT_ROW_W      = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;
    localparam int MAX_HEIGHT         = 4096;

    // Item codes
    localparam logic FUNC_FLUSH = 1'b1;

    // Arithmetic widths
    localparam int GRAD_W   = 11;   // signed gradient, |g| <= 1020
    localparam int SQ_W     = 20;   // one squared gradient
    localparam int SQRT_W   = 16;   // radicand below saturation
    localparam int SQRT_TOP = 14;   // position of the first trial bit
    localparam int MAG_LAT  = 4;    // register stages of the magnitude unit

    typedef struct packed {
        logic            func;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_edge;
        logic [CH_W-1:0] green_edge;
        logic [CH_W-1:0] blue_edge;
        logic            row_end;
        logic            frame_end;
    } t_out_item;

    // Neighbors outside the frame, per side of the window
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_mask;

    // Control that travels beside the magnitude pipeline
    typedef struct packed {
        logic valid;
        logic row_end;
        logic frame_end;
    } t_tag;

    // Window, indexed [column old..new][row top..bottom]
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;
    typedef logic [2:0][2:0][CH_W-1:0]  t_chan_win;

    typedef struct packed {
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] root;
    } t_sqrt;

    // One digit of the bitwise integer square root
    function automatic t_sqrt sqrt_step(input t_sqrt s, input logic [3:0] pos);
        logic [SQRT_W:0] bitv;
        logic [SQRT_W:0] trial;
        t_sqrt           r;
        bitv  = (SQRT_W+1)'(1) << pos;
        trial = {1'b0, s.root} + bitv;
        r     = s;
        if ({1'b0, s.rem} >= trial) begin
            r.rem  = s.rem - trial[SQRT_W-1:0];
            r.root = (s.root >> 1) + bitv[SQRT_W-1:0];
        end else begin
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Frame counters, configuration, the two line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_in_valid,
    input  sem_pkg::t_in_item                 i_in_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output sem_pkg::t_window                  o_win,
    output sem_pkg::t_mask                    o_mask,
    output sem_pkg::t_tag                     o_tag
);
    import sem_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int RST_WIDTH = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : FRAME_WIDTH_RESET;

    logic [WID_W-1:0]          r_width,   n_width;
    logic [FRAME_HEIGHT_W-1:0] r_height,  n_height;
    logic [COL_W-1:0]          r_in_col,  n_in_col;
    logic [ROW_W-1:0]          r_in_row,  n_in_row;
    logic [COL_W-1:0]          r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0]      r_out_row, n_out_row;

    logic [FRAME_WIDTH_W-1:0]  cfg_w;
    logic [FRAME_HEIGHT_W-1:0] cfg_h;
    logic                      cfg_we;
    logic                      in_frame;
    logic                      take;
    logic                      last_col;
    logic                      drain_end;
    logic                      produce;
    t_mask                     mask;
    logic [PIX_W-1:0]          pix;

    // First stage: line store read in flight
    logic                      r_s1_valid;
    logic [COL_W-1:0]          r_s1_addr;
    logic [PIX_W-1:0]          r_s1_pix;
    logic                      r_s1_prod;
    t_mask                     r_s1_mask;
    logic                      r_s1_byp;
    logic [LINE_W-1:0]         r_s1_byp_word;

    logic [LINE_W-1:0]         ram_rdata;
    logic [LINE_W-1:0]         s1_word;
    logic [PIX_W-1:0]          s1_top;
    logic [PIX_W-1:0]          s1_mid;
    logic [LINE_W-1:0]         wr_word;

    // Second stage: window
    t_window                   r_win;
    t_mask                     r_s2_mask;
    t_tag                      r_s2_tag;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign cfg_w       = i_cfg_data[FRAME_WIDTH_W-1:0];
    assign cfg_h       = i_cfg_data[FRAME_HEIGHT_W-1:0];

    // Frame position, masks and counter advance
    always_comb begin
        in_frame  = r_in_row < r_height;
        take      = i_in_valid && i_adv && !(in_frame && (i_in_data.func == FUNC_FLUSH));
        last_col  = (WID_W'(r_in_col) + WID_W'(1)) >= r_width;
        drain_end = {1'b0, r_in_row} >= ({1'b0, r_height} + (ROW_W+1)'(1));
        produce   = (r_in_row >= ROW_W'(2)) ||
                    ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
        pix       = in_frame ? {i_in_data.red, i_in_data.green, i_in_data.blue} : '0;

        mask.left   = r_out_col == '0;
        mask.right  = (WID_W'(r_out_col) + WID_W'(1)) >= r_width;
        mask.top    = r_out_row == '0;
        mask.bottom = (ROW_W'(r_out_row) + ROW_W'(1)) >= r_height;

        n_width   = r_width;
        n_height  = r_height;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        if (take) begin
            if (drain_end) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (produce) begin
                if (mask.right) begin
                    n_out_col = '0;
                    n_out_row = mask.bottom ? '0 : r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end

        // A register write restarts the frame
        if (cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_w == '0) begin
                        n_width = WID_W'(1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        n_width = WID_W'(MAX_WIDTH);
                    end else begin
                        n_width = WID_W'(cfg_w);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_h == '0) begin
                        n_height = FRAME_HEIGHT_W'(1);
                    end else if (cfg_h > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
                        n_height = FRAME_HEIGHT_W'(MAX_HEIGHT);
                    end else begin
                        n_height = cfg_h;
                    end
                end
                default: begin
                end
            endcase
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(RST_WIDTH);
            r_height  <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Line stores: upper half holds the row two back, lower half the row above
    assign s1_word = r_s1_byp ? r_s1_byp_word : ram_rdata;
    assign s1_top  = s1_word[LINE_W-1:PIX_W];
    assign s1_mid  = s1_word[PIX_W-1:0];
    assign wr_word = {s1_mid, r_s1_pix};

    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_adv && r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_word),
        .i_re    (take),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    // First stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= take;
        end
    end

    // First stage payload; forward the word written in the same cycle
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_addr     <= r_in_col;
            r_s1_pix      <= pix;
            r_s1_prod     <= produce;
            r_s1_mask     <= mask;
            r_s1_byp      <= r_s1_valid && (r_s1_addr == r_in_col);
            r_s1_byp_word <= wr_word;
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= {r_s1_pix, s1_mid, s1_top};
        end
        if (i_adv) begin
            r_s2_mask <= r_s1_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
        end else if (i_adv) begin
            r_s2_tag.valid     <= r_s1_valid && r_s1_prod;
            r_s2_tag.row_end   <= r_s1_mask.right;
            r_s2_tag.frame_end <= r_s1_mask.right && r_s1_mask.bottom;
        end
    end

    assign o_win  = r_win;
    assign o_mask = r_s2_mask;
    assign o_tag  = r_s2_tag;

endmodule

>>> rtl/sem_mag.sv
// ----------------------------------------------------------------------------
// sem_mag
// Sobel gradients and saturated magnitude of one color channel.
// ----------------------------------------------------------------------------
module sem_mag (
    input  logic                   i_clk,
    input  logic                   i_adv,
    input  sem_pkg::t_chan_win     i_win,
    input  sem_pkg::t_mask         i_mask,
    output logic [sem_pkg::CH_W-1:0] o_edge
);
    import sem_pkg::*;

    t_chan_win                 v;
    logic [CH_W+1:0]           sum_l, sum_r, sum_t, sum_b;
    logic signed [GRAD_W-1:0]  gx, gy;
    logic signed [GRAD_W-1:0]  r_gx, r_gy;
    logic signed [2*GRAD_W-1:0] px, py;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [SQ_W:0]             sq_sum;
    logic                      r_sat, r_sat2;
    logic [SQRT_W-1:0]         r_v;
    t_sqrt                     st_a, st_b;
    t_sqrt                     r_half;

    // Zero the neighbors outside the frame, then form the gradients
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if ((c == 0 && i_mask.left) || (c == 2 && i_mask.right) ||
                    (r == 0 && i_mask.top)  || (r == 2 && i_mask.bottom)) begin
                    v[c][r] = '0;
                end else begin
                    v[c][r] = i_win[c][r];
                end
            end
        end
        sum_l = (CH_W+2)'(v[0][0]) + {1'b0, v[0][1], 1'b0} + (CH_W+2)'(v[0][2]);
        sum_r = (CH_W+2)'(v[2][0]) + {1'b0, v[2][1], 1'b0} + (CH_W+2)'(v[2][2]);
        sum_t = (CH_W+2)'(v[0][0]) + {1'b0, v[1][0], 1'b0} + (CH_W+2)'(v[2][0]);
        sum_b = (CH_W+2)'(v[0][2]) + {1'b0, v[1][2], 1'b0} + (CH_W+2)'(v[2][2]);
        gx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        gy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    end

    // Square the gradients
    assign px = r_gx * r_gx;
    assign py = r_gy * r_gy;

    // Sum of squares, saturate at 256 squared
    assign sq_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // First half of the root digits
    always_comb begin
        st_a.rem  = r_v;
        st_a.root = '0;
        for (int k = 0; k < 4; k++) begin
            st_a = sqrt_step(st_a, 4'(SQRT_TOP - 2 * k));
        end
    end

    // Second half of the root digits
    always_comb begin
        st_b = r_half;
        for (int k = 4; k < 8; k++) begin
            st_b = sqrt_step(st_b, 4'(SQRT_TOP - 2 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gx   <= gx;
            r_gy   <= gy;
            r_sqx  <= px[SQ_W-1:0];
            r_sqy  <= py[SQ_W-1:0];
            r_sat  <= |sq_sum[SQ_W:SQRT_W];
            r_v    <= sq_sum[SQRT_W-1:0];
            r_half <= st_a;
            r_sat2 <= r_sat;
        end
    end

    assign o_edge = r_sat2 ? {CH_W{1'b1}} : st_b.root[CH_W-1:0];

endmodule

>>> rtl/sem_skid.sv
// ----------------------------------------------------------------------------
// sem_skid
// Output register with one skid entry; decouples the pipeline from stall.
// ----------------------------------------------------------------------------
module sem_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sem_pkg::t_out_item i_data,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sem_pkg::t_out_item o_out_data
);
    import sem_pkg::*;

    logic      r_out_valid,  n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_out_data;
    t_out_item r_skid_data;
    logic      load;

    // Refill the output register when empty or on a transfer
    always_comb begin
        load         = !r_out_valid || !i_out_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (load) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/sobel_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// Streaming per-channel 3x3 Sobel edge magnitude of an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (valid/stall). Results
// leave on the output channel with row_end and frame_end marks; the result
// of a pixel comes out with the input item that lies frame_width+1 items
// later, so a frame is closed by frame_width+1 flush items. Flush items
// inside the frame are taken and dropped.
// One item is taken per clock while o_in_stall is low. The result of the item
// that completes a window reaches o_out_valid through the line store read,
// the window register, then gradient, square, sum and two square-root stages
// (four digits each, the second one into the output register).
// Configuration writes (frame_width, frame_height) are taken at once and
// restart the frame; write them only while the block is idle.
// Reset clears counters and valid bits and loads 640 x 480. The line stores
// are not cleared: stale entries only ever fall on out-of-frame neighbors.
// When the receiver stalls, the output register and a skid entry absorb the
// pipeline; o_in_stall is high while the skid entry is occupied, and the
// whole pipeline holds until it drains.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sem_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sem_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sem_pkg::*;

    logic            adv;
    logic            skid_full;
    t_window         win;
    t_mask           mask;
    t_tag            tag;
    t_tag            r_tag [MAG_LAT];
    t_chan_win       win_ch [3];
    logic [CH_W-1:0] edge_ch [3];
    t_out_item       result;

    // The whole pipeline moves while the skid entry is free
    assign adv        = !skid_full;
    assign o_in_stall = skid_full;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_win       (win),
        .o_mask      (mask),
        .o_tag       (tag)
    );

    // Split the window into color planes
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_ch[ch][c][r] = win[c][r][CH_W*ch +: CH_W];
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_chan
        sem_mag u_mag (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_win  (win_ch[g]),
            .i_mask (mask),
            .o_edge (edge_ch[g])
        );
    end

    // Carry valid and row marks beside the magnitude stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAG_LAT; s++) begin
                r_tag[s] <= '0;
            end
        end else if (adv) begin
            r_tag[0] <= tag;
            for (int s = 1; s < MAG_LAT; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_comb begin
        result.red_edge   = edge_ch[2];
        result.green_edge = edge_ch[1];
        result.blue_edge  = edge_ch[0];
        result.row_end    = r_tag[MAG_LAT-1].row_end;
        result.frame_end  = r_tag[MAG_LAT-1].frame_end;
    end

    sem_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (adv && r_tag[MAG_LAT-1].valid),
        .i_data      (result),
        .o_full      (skid_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sobel_edge_magnitude_core. Frames of RGB pixels are
// streamed in with flush items mixed in. A behavioral Sobel predictor turns
// every transfer into the edge magnitudes it should cause. A checker compares
// each output transfer with the oldest prediction. Frame sizes, sender gaps
// and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
    import sem_pkg::*;

    localparam int   MAX_W      = 2048;
    localparam int   LIMIT      = 1_000_000;
    localparam int   SETTLE     = 16;
    localparam int   HOLD_LEN   = 300;
    localparam int   REPORT_MAX = 10;
    localparam logic FUNC_PIXEL = ~FUNC_FLUSH;

    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_FLAT} t_texture;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int items_taken    = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // Predictor state: line stores, window, counters and frame registers
    logic [PIX_W-1:0]          upper_line [MAX_W];
    logic [PIX_W-1:0]          middle_line [MAX_W];
    logic [PIX_W-1:0]          win [3][3];
    int unsigned               in_col, in_row, out_col, out_row;
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    t_out_item                 pending_mags [$];

    always #5 i_clk = ~i_clk;

    sobel_edge_magnitude_core #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_W) return unsigned'(MAX_W);
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return unsigned'(MAX_HEIGHT);
        return 32'(height_reg);
    endfunction

    function automatic void restart_counters();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void reset_model();
        width_reg  = FRAME_WIDTH_W'(FRAME_WIDTH_RESET);
        height_reg = FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
        for (int n = 0; n < MAX_W; n++) begin
            upper_line[n]  = '0;
            middle_line[n] = '0;
        end
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                win[c][r] = '0;
        restart_counters();
    endfunction

    // Floor of the square root, saturated to 8 bits
    function automatic logic [CH_W-1:0] root_sat(int unsigned s);
        int unsigned      t;
        logic [CH_W-1:0]  r;
        if (s >= 255 * 255) return 8'hFF;
        r = '0;
        for (int b = CH_W - 1; b >= 0; b--) begin
            t = 32'(r) | (32'(1) << b);
            if (t * t <= s) r = t[CH_W-1:0];
        end
        return r;
    endfunction

    // Sobel magnitude of one channel with out-of-frame sides zeroed
    function automatic logic [CH_W-1:0] channel_mag(int shift, bit ml, bit mr,
                                                     bit mt, bit mb);
        int v [3][3];
        int gx, gy;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++) begin
                if ((c == 0 && ml) || (c == 2 && mr) || (r == 0 && mt) || (r == 2 && mb))
                    v[c][r] = 0;
                else
                    v[c][r] = int'(win[c][r][shift +: CH_W]);
            end
        gx = (v[0][0] + 2 * v[0][1] + v[0][2]) - (v[2][0] + 2 * v[2][1] + v[2][2]);
        gy = (v[0][0] + 2 * v[1][0] + v[2][0]) - (v[0][2] + 2 * v[1][2] + v[2][2]);
        return root_sat(unsigned'(gx * gx + gy * gy));
    endfunction

    // Advance the predictor by one transfer, queue the result it causes
    function automatic void sobel_step(t_in_item it);
        int unsigned      w, h, pos;
        logic [PIX_W-1:0] pix;
        bit               in_frame, ml, mr, mt, mb;
        t_out_item        res;
        w = active_width();
        h = active_height();
        in_frame = in_row < h;
        // drop flush items while pixels of the frame are still due
        if (in_frame && it.func == FUNC_FLUSH) return;
        items_taken++;
        pix = in_frame ? {it.red, it.green, it.blue} : '0;
        for (int r = 0; r < 3; r++) begin
            win[0][r] = win[1][r];
            win[1][r] = win[2][r];
        end
        win[2][0] = upper_line[in_col];
        win[2][1] = middle_line[in_col];
        win[2][2] = pix;
        upper_line[in_col]  = middle_line[in_col];
        middle_line[in_col] = pix;
        pos = in_row * w + in_col;
        if (in_row >= h + 1) begin
            in_col = 0;
            in_row = 0;
        end else if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (pos < w + 1) return;
        ml = out_col == 0;
        mr = out_col + 1 >= w;
        mt = out_row == 0;
        mb = out_row + 1 >= h;
        res.red_edge   = channel_mag(16, ml, mr, mt, mb);
        res.green_edge = channel_mag(8, ml, mr, mt, mb);
        res.blue_edge  = channel_mag(0, ml, mr, mt, mb);
        res.row_end    = mr;
        res.frame_end  = mr && mb;
        pending_mags.push_back(res);
        if (mr) begin
            out_col = 0;
            out_row = mb ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic t_in_item item_of(logic f, logic [CH_W-1:0] r,
                                         logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        t_in_item it;
        it.func  = f;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return item_of(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [CH_W-1:0] texel(t_texture tex);
        case (tex)
            TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            TEX_FLAT:   return 8'($urandom_range(100, 103));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item make_pixel(t_texture tex);
        return item_of(FUNC_PIXEL, texel(tex), texel(tex), texel(tex));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Offer one item, hold it until the transfer, then predict
    task automatic send_item(t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sobel_step(it);
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_mags.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one register write and hold it until the transfer
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FRAME_WIDTH) width_reg = data[FRAME_WIDTH_W-1:0];
        else height_reg = data[FRAME_HEIGHT_W-1:0];
        restart_counters();
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // Send a frame (or its first cut pixels), then the drain if it completed
    task automatic send_frame(int unsigned w, int unsigned h, t_texture tex,
                              int flush_pct, int unsigned cut);
        int unsigned npix;
        t_in_item    it;
        npix = (cut != 0 && cut < w * h) ? cut : w * h;
        for (int unsigned n = 0; n < npix; n++) begin
            if ($urandom_range(0, 99) < flush_pct) begin
                it = random_item();
                it.func = FUNC_FLUSH;
                send_item(it);
            end
            send_item(make_pixel(tex));
        end
        if (npix == w * h)
            for (int unsigned n = 0; n <= w; n++)
                send_item(random_item());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_corner_cases();
        set_idling(0, 0);
        // reset size 640 x 480: a partial first row yields nothing
        for (int n = 0; n < 5; n++)
            send_item(item_of(FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF));
        // register write restarts the frame; 3 x 2 of full-scale steps
        set_frame(13'd3, 13'd2);
        for (int n = 0; n < 6; n++) begin
            send_item(item_of(FUNC_PIXEL, n[0] ? 8'hFF : 8'h00, (n < 3) ? 8'hFF : 8'h00,
                              (n == 4) ? 8'hFF : 8'h00));
            // flush inside the frame is dropped
            if (n == 2) send_item(item_of(FUNC_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        end
        // drain takes flush and pixel items alike, colour ignored
        send_item(item_of(FUNC_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(FUNC_FLUSH, 8'h00, 8'h00, 8'h00));
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        // narrow frames: 1 x 1 and 2 x 1
        set_frame(13'd1, 13'd1);
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(FUNC_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        set_frame(13'd2, 13'd1);
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF));
        send_item(item_of(FUNC_PIXEL, 8'h00, 8'hFF, 8'h00));
        send_item(item_of(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_item(item_of(FUNC_FLUSH, 8'h00, 8'h00, 8'h00));
        send_item(item_of(FUNC_PIXEL, 8'h00, 8'h00, 8'h00));
        wait_drained();
    endtask

    // Register extremes: zero width and height act as one; out-of-range
    // values are clamped, followed by a short cut of that frame
    task automatic test_size_limits();
        set_idling(0, 0);
        set_frame(13'd0, 13'd3);
        send_frame(1, 3, TEX_NOISE, 0, 0);
        set_frame(13'd4, 13'd0);
        send_frame(4, 1, TEX_BINARY, 0, 0);
        set_frame(13'h1FFF, 13'h1FFF);
        send_frame(MAX_W, MAX_HEIGHT, TEX_NOISE, 0, 40);
        wait_drained();
    endtask

    // Random small frames, mostly whole, some cut short, flushes mixed in
    task automatic test_random_frames(int send_pct, int recv_pct, int budget);
        int unsigned w, h, cut;
        int          start;
        bit          fresh;
        t_texture    tex;
        wait_drained();
        set_idling(send_pct, recv_pct);
        start = items_taken;
        fresh = 1'b1;
        w = 1;
        h = 1;
        while (items_taken - start < budget) begin
            if (fresh || $urandom_range(0, 99) < 60) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                 : $urandom_range(1, 6);
                h = $urandom_range(1, 6);
                set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
            end
            tex = t_texture'($urandom_range(0, 2));
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : 0;
            send_frame(w, h, tex, 8, cut);
            fresh = cut != 0 && cut < w * h;
        end
        wait_drained();
    endtask

    // Long receiver hold while the sender keeps offering: fill the block
    task automatic test_output_hold();
        set_idling(0, 0);
        set_frame(13'd8, 13'd4);
        hold_reqs <= hold_reqs + 1;
        send_frame(8, 4, TEX_NOISE, 0, 0);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall: random, or a counted hold when requested
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(0, 99) < recv_stall_pct;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic string item_text(t_out_item it);
        return $sformatf("r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b", it.red_edge,
                         it.green_edge, it.blue_edge, it.row_end, it.frame_end);
    endfunction

    task automatic log_mismatch(string what, t_out_item want, t_out_item got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t %s: exp %s, got %s", $realtime, what, item_text(want),
                     item_text(got));
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_mags.size() == 0) begin
                log_mismatch("result with nothing expected", '0, o_out_data);
            end else begin
                want = pending_mags.pop_front();
                if (want.red_edge !== o_out_data.red_edge
                        || want.green_edge !== o_out_data.green_edge
                        || want.blue_edge !== o_out_data.blue_edge
                        || want.row_end !== o_out_data.row_end
                        || want.frame_end !== o_out_data.frame_end)
                    log_mismatch("edge result differs", want, o_out_data);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_size_limits();
        test_random_frames(0, 0, 100);
        test_random_frames(79, 0, 100);
        test_random_frames(0, 79, 100);
        test_random_frames(34, 34, 100);
        test_output_hold();
        wait_drained();
        if (error_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
